/* hdl/rcfd_pkg.sv */
// Shared types and constants of the remote-control frame decoder.
package rcfd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned PosW      = 4;
  localparam int unsigned CountW    = 16;
  localparam int unsigned ModeW     = 3;
  localparam int unsigned NumChan   = 8;
  localparam int unsigned ChanIdxW  = $clog2(NumChan);
  localparam int unsigned QDepth    = 4;
  localparam int unsigned OutW      = 96;

  localparam logic [PosW-1:0] PosHead  = 4'd0;
  localparam logic [PosW-1:0] PosLastCh = 4'd8;
  localparam logic [PosW-1:0] PosSwitch = 4'd9;
  localparam logic [PosW-1:0] PosSpare = 4'd10;
  localparam logic [PosW-1:0] PosCheck = 4'd11;
  localparam logic [PosW-1:0] PosDone  = 4'd13;

  localparam logic [ByteW-1:0] HeadReset = 8'hA5;
  localparam logic [ByteW-1:0] TailReset = 8'h5A;
  localparam logic [ByteW-1:0] Centre    = 8'd128;

  localparam logic CfgHead = 1'b0;
  localparam logic CfgTail = 1'b1;

  localparam logic [ModeW-1:0] ModeNone  = 3'd0;
  localparam logic [ModeW-1:0] ModeBoth  = 3'd1;
  localparam logic [ModeW-1:0] ModeSw1   = 3'd2;
  localparam logic [ModeW-1:0] ModeSw2   = 3'd3;
  localparam logic [ModeW-1:0] ModeSw0   = 3'd4;
  localparam logic [ModeW-1:0] ModeSw3   = 3'd6;

  typedef enum logic [1:0] {
    OP_HEAD,
    OP_DATA,
    OP_CHECK,
    OP_TAIL
  } rcfd_op_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_HEAD,
    ST_BAD_TAIL,
    ST_BAD_SUM
  } rcfd_status_e;

  typedef struct packed {
    rcfd_op_e         op;
    logic [PosW-1:0]  pos;
    logic [ByteW-1:0] data;
  } rcfd_cmd_t;

  typedef struct packed {
    logic      valid;
    rcfd_cmd_t cmd;
  } rcfd_req_t;

endpackage

/* hdl/rcfd_front.sv */
// Front end: tracks byte position and classifies each received byte.
module rcfd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // byte_value[7:0]
  input  logic [0:0]                s_axis_tuser,  // frame_start[0]
  input  logic                      q_full_i,
  output rcfd_pkg::rcfd_req_t       push_o
);

  logic [rcfd_pkg::PosW-1:0] pos_q, pos_d, pos_c;
  logic                      accept_c, done_c;
  rcfd_pkg::rcfd_op_e        op_c;

  assign s_axis_tready = ~q_full_i;
  assign accept_c      = s_axis_tvalid & s_axis_tready;
  assign pos_c         = s_axis_tuser[0] ? rcfd_pkg::PosHead : pos_q;
  assign done_c        = (pos_c >= rcfd_pkg::PosDone);

  always_comb begin
    priority if (pos_c == rcfd_pkg::PosHead) begin
      op_c = rcfd_pkg::OP_HEAD;
    end else if (pos_c <= rcfd_pkg::PosSpare) begin
      op_c = rcfd_pkg::OP_DATA;
    end else if (pos_c == rcfd_pkg::PosCheck) begin
      op_c = rcfd_pkg::OP_CHECK;
    end else begin
      op_c = rcfd_pkg::OP_TAIL;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (accept_c) begin
      pos_d = done_c ? pos_c : pos_c + 4'd1;
    end
  end

  assign push_o.valid    = accept_c & ~done_c;
  assign push_o.cmd.op   = op_c;
  assign push_o.cmd.pos  = pos_c;
  assign push_o.cmd.data = s_axis_tdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= rcfd_pkg::PosHead;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

/* hdl/rcfd_fifo.sv */
// Short command queue between front and back end.
module rcfd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rcfd_pkg::rcfd_req_t   push_i,
  output logic                  full_o,
  output rcfd_pkg::rcfd_req_t   head_o,
  input  logic                  pop_i
);

  localparam int unsigned PtrW = $clog2(rcfd_pkg::QDepth);
  localparam int unsigned CntW = $clog2(rcfd_pkg::QDepth + 1);

  rcfd_pkg::rcfd_cmd_t mem_q [rcfd_pkg::QDepth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(rcfd_pkg::QDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_q];
  assign do_push      = push_i.valid & ~full_o;
  assign do_pop       = pop_i & head_o.valid;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.cmd;
    end
  end

endmodule

/* hdl/rcfd_back.sv */
// Back end: stores frame bytes, judges the frame and registers the result.
module rcfd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rcfd_pkg::rcfd_req_t       head_i,
  output logic                      pop_o,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_index_i,
  input  logic [7:0]                cfg_data_i,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [rcfd_pkg::OutW-1:0] m_axis_tdata
);

  localparam int unsigned B = rcfd_pkg::ByteW;

  function automatic logic [rcfd_pkg::ModeW-1:0] mode_of(input logic [B-1:0] sw);
    logic [rcfd_pkg::ModeW-1:0] m;
    if (sw[0]) begin
      m = sw[1] ? rcfd_pkg::ModeBoth : rcfd_pkg::ModeSw0;
    end else begin
      m = sw[1] ? rcfd_pkg::ModeSw1 : rcfd_pkg::ModeNone;
    end
    if (sw[2]) begin
      m = rcfd_pkg::ModeSw2;
    end
    if (sw[3]) begin
      m = rcfd_pkg::ModeSw3;
    end
    return m;
  endfunction

  logic [B-1:0]                 head_reg_q, tail_reg_q;
  logic                         head_ok_q;
  logic [B-1:0]                 sum_q;
  logic [B-1:0]                 ch_q [rcfd_pkg::NumChan];
  logic [B-1:0]                 sw_q, ck_q;
  logic [rcfd_pkg::CountW-1:0]  cnt_q, cnt_d;
  logic                         out_valid_q;
  logic [rcfd_pkg::OutW-1:0]    out_q, out_d;

  rcfd_pkg::rcfd_cmd_t          cmd;
  rcfd_pkg::rcfd_status_e       status_c;
  logic                         out_free, exec, is_tail, load_out;
  logic [rcfd_pkg::PosW-1:0]    idx_c;
  logic [B*7-1:0]               centred_c;

  assign cmd      = head_i.cmd;
  assign is_tail  = (cmd.op == rcfd_pkg::OP_TAIL);
  assign out_free = ~out_valid_q | m_axis_tready;
  assign exec     = head_i.valid & (~is_tail | out_free);
  assign pop_o    = exec;
  assign load_out = exec & is_tail;
  assign idx_c    = cmd.pos - 4'd1;

  always_comb begin
    priority if (!head_ok_q) begin
      status_c = rcfd_pkg::ST_BAD_HEAD;
    end else if (cmd.data != tail_reg_q) begin
      status_c = rcfd_pkg::ST_BAD_TAIL;
    end else if (sum_q != ck_q) begin
      status_c = rcfd_pkg::ST_BAD_SUM;
    end else begin
      status_c = rcfd_pkg::ST_OK;
    end
  end

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      centred_c[i*B +: B] = ch_q[i] - rcfd_pkg::Centre;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    out_d = '0;
    if (status_c == rcfd_pkg::ST_OK) begin
      cnt_d        = cnt_q + 16'd1;
      out_d[57:2]  = centred_c;
      out_d[65:58] = ch_q[7];
      out_d[73:66] = sw_q;
      out_d[76:74] = mode_of(sw_q);
    end
    out_d[1:0]   = status_c;
    out_d[92:77] = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_reg_q  <= rcfd_pkg::HeadReset;
      tail_reg_q  <= rcfd_pkg::TailReset;
      head_ok_q   <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          rcfd_pkg::CfgHead: head_reg_q <= cfg_data_i;
          rcfd_pkg::CfgTail: tail_reg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (exec) begin
        unique case (cmd.op)
          rcfd_pkg::OP_HEAD: begin
            head_ok_q <= (cmd.data == head_reg_q);
            sum_q     <= '0;
          end
          rcfd_pkg::OP_DATA: sum_q <= sum_q + cmd.data;
          rcfd_pkg::OP_TAIL: cnt_q <= cnt_d;
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && cmd.op == rcfd_pkg::OP_DATA) begin
      for (int i = 0; i < rcfd_pkg::NumChan; i++) begin
        if (cmd.pos <= rcfd_pkg::PosLastCh && idx_c[rcfd_pkg::ChanIdxW-1:0] == i[2:0]) begin
          ch_q[i] <= cmd.data;
        end
      end
      if (cmd.pos == rcfd_pkg::PosSwitch) begin
        sw_q <= cmd.data;
      end
    end
    if (exec && cmd.op == rcfd_pkg::OP_CHECK) begin
      ck_q <= cmd.data;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

/* hdl/rc_frame_decoder.sv */
// Top level of the remote-control frame decoder.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata byte_value, tuser frame_start
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata decoded frame result
//  cfg       in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
//  One byte per cycle while the queue has room; results leave from a register.
//  The four-entry command queue and the result register decouple both sides.
//  A stalled output holds the result; the tail stays queued, earlier bytes go on.
//  Reset clears position, sum, counter; presets head/tail registers; no clearing pass.
module rc_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // byte_value[7:0]
  input  logic [0:0]  s_axis_tuser,  // frame_start[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0] rudder[9:2] throttle[17:10] aileron[25:18] elevator[33:26]
  // x_axis[41:34] y_axis[49:42] z_axis[57:50] claw[65:58] switches[73:66]
  // drive_mode[76:74] frame_count[92:77] zero[95:93]
  output logic [95:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  rcfd_pkg::rcfd_req_t push, head;
  logic                full, pop;

  assign cfg_ready_o = 1'b1;

  rcfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (full),
    .push_o        (push)
  );

  rcfd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  rcfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* hdl/rcfd_checker.sv */
// Port-level assertions for the frame decoder and their bind.
module rcfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid in reset");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != rcfd_pkg::ST_OK |-> m_axis_tdata[76:2] == '0)
    else $error("bad frame carries data");

  a_mode_sw3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == rcfd_pkg::ST_OK && m_axis_tdata[69]
    |-> m_axis_tdata[76:74] == rcfd_pkg::ModeSw3)
    else $error("switch 3 mode wrong");

endmodule

bind rc_frame_decoder rcfd_checker u_rcfd_checker (.*);

/* sim/rc_frame_decoder_tb.sv */
// Self-checking testbench of the remote-control frame decoder: byte stream in, decoded frames out.
module rc_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcfd_pkg::*;

  typedef struct packed {
    logic [2:0]        pad;
    logic [15:0]       frame_count;
    logic [2:0]        drive_mode;
    logic [7:0]        switches;
    logic [7:0]        claw;
    logic signed [7:0] z_axis, y_axis, x_axis, elevator, aileron, throttle, rudder;
    rcfd_status_e      status;
  } frame_res_t;

  typedef enum logic [1:0] {BY_MODEL, GOOD_EXTREMES} want_e;
  typedef enum logic [1:0] {BYTE_IGNORED, BYTE_TAKEN, BYTE_DONE} byte_fate_e;

  typedef struct packed {
    logic [7:0] value;
    logic       start;
    want_e      want;
  } stim_row_t;

  localparam int NumRows    = 28;
  localparam int TailPos    = PosDone - 1;
  localparam int PhaseItems = 130;
  localparam int HoldCycles = 400;
  localparam int CycleLimit = 100000;

  localparam frame_res_t EXTREMES_WANT = '{pad: 3'd0, frame_count: 16'd1,
    drive_mode: ModeSw3, switches: 8'h0F, claw: 8'hAA, z_axis: 8'hD5, y_axis: 8'h7E,
    x_axis: 8'h81, elevator: 8'hFF, aileron: 8'h00, throttle: 8'h7F, rudder: 8'h80,
    status: ST_OK};

  localparam stim_row_t DIRECTED [NumRows] = '{
    '{8'hA5, 1'b0, BY_MODEL}, '{8'h00, 1'b0, BY_MODEL}, '{8'hFF, 1'b0, BY_MODEL},
    '{8'h80, 1'b0, BY_MODEL}, '{8'h7F, 1'b0, BY_MODEL}, '{8'h01, 1'b0, BY_MODEL},
    '{8'hFE, 1'b0, BY_MODEL}, '{8'h55, 1'b0, BY_MODEL}, '{8'hAA, 1'b0, BY_MODEL},
    '{8'h0F, 1'b0, BY_MODEL}, '{8'h33, 1'b0, BY_MODEL}, '{8'h3E, 1'b0, BY_MODEL},
    '{8'h5A, 1'b0, GOOD_EXTREMES},
    '{8'hFF, 1'b0, BY_MODEL},
    '{8'hA5, 1'b1, BY_MODEL}, '{8'h77, 1'b0, BY_MODEL},
    '{8'hA5, 1'b1, BY_MODEL}, '{8'h80, 1'b0, BY_MODEL}, '{8'h80, 1'b0, BY_MODEL},
    '{8'h80, 1'b0, BY_MODEL}, '{8'h80, 1'b0, BY_MODEL}, '{8'h80, 1'b0, BY_MODEL},
    '{8'h80, 1'b0, BY_MODEL}, '{8'h80, 1'b0, BY_MODEL}, '{8'h00, 1'b0, BY_MODEL},
    '{8'h03, 1'b0, BY_MODEL}, '{8'h00, 1'b0, BY_MODEL}, '{8'h83, 1'b0, BY_MODEL}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i   = CfgHead;
  logic [7:0]  cfg_data_i    = '0;

  logic [7:0]  cfg_head   = HeadReset;
  logic [7:0]  cfg_tail   = TailReset;
  logic [3:0]  rx_pos     = PosHead;
  logic [7:0]  rx_sum     = '0;
  logic        rx_head_ok = 1'b0;
  logic [7:0]  rx_chan [NumChan];
  logic [7:0]  rx_sw;
  logic [7:0]  rx_chk;
  logic [15:0] frames_ok  = '0;

  frame_res_t expected_frames [$];
  int  items_taken  = 0;
  int  results_seen = 0;
  int  mismatches   = 0;
  int  cycles       = 0;
  bit  stress_armed = 1'b0;

  rc_frame_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic byte_fate_e decode_byte(input logic [7:0] b, input logic st,
                                             output frame_res_t r);
    logic [3:0] p;
    logic [2:0] m;
    r = '0;
    if (st) rx_pos = PosHead;
    p = rx_pos;
    if (p >= PosDone) return BYTE_IGNORED;
    rx_pos = p + 4'd1;
    if (p == PosHead) begin
      rx_head_ok = (b == cfg_head);
      rx_sum = '0;
      return BYTE_TAKEN;
    end
    if (p <= PosSpare) begin
      rx_sum += b;
      if (p <= PosLastCh) rx_chan[3'(p - 4'd1)] = b;
      else if (p == PosSwitch) rx_sw = b;
      return BYTE_TAKEN;
    end
    if (p == PosCheck) begin
      rx_chk = b;
      return BYTE_TAKEN;
    end
    if (!rx_head_ok) r.status = ST_BAD_HEAD;
    else if (b != cfg_tail) r.status = ST_BAD_TAIL;
    else if (rx_sum != rx_chk) r.status = ST_BAD_SUM;
    else r.status = ST_OK;
    if (r.status == ST_OK) begin
      frames_ok++;
      case (rx_sw[1:0])
        2'b11:   m = ModeBoth;
        2'b01:   m = ModeSw0;
        2'b10:   m = ModeSw1;
        default: m = ModeNone;
      endcase
      if (rx_sw[2]) m = ModeSw2;
      if (rx_sw[3]) m = ModeSw3;
      r.rudder     = rx_chan[0] - Centre;
      r.throttle   = rx_chan[1] - Centre;
      r.aileron    = rx_chan[2] - Centre;
      r.elevator   = rx_chan[3] - Centre;
      r.x_axis     = rx_chan[4] - Centre;
      r.y_axis     = rx_chan[5] - Centre;
      r.z_axis     = rx_chan[6] - Centre;
      r.claw       = rx_chan[7];
      r.switches   = rx_sw;
      r.drive_mode = m;
    end
    r.frame_count = frames_ok;
    return BYTE_DONE;
  endfunction

  function automatic int pick_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return Centre;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h, want %h", results_seen, name, got, want));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic st, input int gap,
                           input want_e want = BY_MODEL);
    frame_res_t r;
    byte_fate_e fate;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    do @(posedge clk_i); while (!s_axis_tready);
    fate = decode_byte(b, st, r);
    if (fate != BYTE_IGNORED) items_taken++;
    if (fate == BYTE_DONE) expected_frames.push_back(want == GOOD_EXTREMES ? EXTREMES_WANT : r);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [7:0] head, input logic [7:0] tail);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgHead;
    cfg_data_i  <= head;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_head = head;
    cfg_index_i <= CfgTail;
    cfg_data_i  <= tail;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_tail = tail;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_frame(input bit quiet);
    logic [7:0] f [PosDone];
    logic [7:0] sum;
    int kind, len;
    quiet = quiet || ($urandom_range(0, 3) == 0);
    sum = '0;
    f[PosHead] = cfg_head;
    for (int k = 1; k <= PosSpare; k++) begin
      f[k] = pick_byte();
      sum += f[k];
    end
    f[PosCheck] = sum;
    f[TailPos]  = cfg_tail;
    kind = $urandom_range(0, 99);
    len  = PosDone;
    if (kind < 8) f[PosHead] ^= 8'($urandom_range(1, 255));
    else if (kind < 16) f[TailPos] ^= 8'($urandom_range(1, 255));
    else if (kind < 24) f[PosCheck] ^= 8'($urandom_range(1, 255));
    else if (kind < 28) begin
      f[PosHead]  ^= 8'($urandom_range(1, 255));
      f[TailPos]  ^= 8'($urandom_range(1, 255));
      f[PosCheck] ^= 8'($urandom_range(1, 255));
    end else if (kind < 36) len = $urandom_range(1, TailPos);
    for (int k = 0; k < len; k++) send_byte(f[k], k == 0, pick_gap(quiet));
    if (kind >= 36 && kind < 44)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, pick_gap(quiet));
    else if (kind >= 44 && kind < 50)
      repeat ($urandom_range(1, 4))
        send_byte(8'($urandom), 1'($urandom_range(0, 1)), pick_gap(quiet));
  endtask

  initial begin
    int gap;
    bit calm;
    calm = 1'b0;
    wait (rst_ni);
    forever begin
      if (results_seen % 10 == 0) calm = ($urandom_range(0, 2) == 0);
      gap = pick_gap(calm);
      if (stress_armed) begin
        stress_armed = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    frame_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_seen++;
      if (expected_frames.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
      end else begin
        want = expected_frames.pop_front();
        check_field("status", got.status, want.status);
        check_field("rudder", got.rudder, want.rudder);
        check_field("throttle", got.throttle, want.throttle);
        check_field("aileron", got.aileron, want.aileron);
        check_field("elevator", got.elevator, want.elevator);
        check_field("x_axis", got.x_axis, want.x_axis);
        check_field("y_axis", got.y_axis, want.y_axis);
        check_field("z_axis", got.z_axis, want.z_axis);
        check_field("claw", got.claw, want.claw);
        check_field("switches", got.switches, want.switches);
        check_field("drive_mode", got.drive_mode, want.drive_mode);
        check_field("frame_count", got.frame_count, want.frame_count);
        check_field("pad", got.pad, want.pad);
      end
    end
  end

  initial begin
    logic [7:0] head_set [6];
    logic [7:0] tail_set [6];
    int goal;
    head_set = '{8'h00, 8'hFF, 8'h3C, 8'($urandom), 8'($urandom), HeadReset};
    tail_set = '{8'hFF, 8'h00, 8'hC3, 8'($urandom), 8'($urandom), TailReset};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DIRECTED[i])
      send_byte(DIRECTED[i].value, DIRECTED[i].start, pick_gap(1'b0), DIRECTED[i].want);
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      load_regs(head_set[ph], tail_set[ph]);
      // close the frame opened under the old head register
      if (ph == 0) send_byte(tail_set[0], 1'b0, pick_gap(1'b0));
      if (ph == 2) stress_armed = 1'b1;
      goal = items_taken + PhaseItems;
      while (items_taken < goal) send_random_frame(ph == 2);
    end
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
